>>> rtl/spf_pkg.sv
`default_nettype none
package spf_pkg;
   // Corner store depth and derived widths.
   localparam int MAX_CORNERS = 16;
   localparam int IDX_W = $clog2(MAX_CORNERS);
   localparam int CNT_W = $clog2(MAX_CORNERS + 2);
   localparam int SPAN_CAP = 8;
   localparam int SPAN_W = $clog2(SPAN_CAP + 1);
   localparam int CROSS_W = 48;

   // Request functions.
   localparam logic FUNC_VERTEX = 1'b0;
   localparam logic FUNC_ROW = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_SPAN = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   typedef struct packed {
      logic func;
      logic signed [15:0] vert_x;
      logic signed [15:0] vert_y;
      logic last_vertex;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic signed [15:0] span_row;
      logic signed [15:0] span_start;
      logic signed [15:0] span_end;
      logic row_done;
      logic polygon_done;
   } rsp_type;
endpackage
`default_nettype wire

>>> rtl/scanline_polygon_fill.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  spf_pkg::req_type
// rsp_      out        rsp_valid/rsp_stall  spf_pkg::rsp_type
// The result of a vertex request is registered in the cycle after acceptance. A row
// request runs setup, then for each edge a read and a row test, then for each crossing
// edge the 32-step divider, multiply, add and insertion shifts, then emit per span.
// Reset is synchronous and clears the control state; the stores need none.
// A stalled result holds in the output register and blocks the sequencer.
module scanline_polygon_fill (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire spf_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      spf_pkg::rsp_type rsp_data
);
   import spf_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_P1   = 4'd1;
   localparam logic [3:0] ST_P2   = 4'd2;
   localparam logic [3:0] ST_RD   = 4'd3;
   localparam logic [3:0] ST_EDGE = 4'd4;
   localparam logic [3:0] ST_DIV  = 4'd5;
   localparam logic [3:0] ST_MUL  = 4'd6;
   localparam logic [3:0] ST_ADD  = 4'd7;
   localparam logic [3:0] ST_INS  = 4'd8;
   localparam logic [3:0] ST_NEXT = 4'd9;
   localparam logic [3:0] ST_EMIT = 4'd10;
   localparam logic [3:0] ST_E1   = 4'd11;
   localparam logic [3:0] ST_E2   = 4'd12;
   localparam logic [3:0] ST_E3   = 4'd13;

   // Corner memories and crossing registers.
   logic signed [15:0] corner_x [MAX_CORNERS];
   logic signed [15:0] corner_y [MAX_CORNERS];
   logic signed [CROSS_W-1:0] cross_ff [MAX_CORNERS];

   logic [3:0] state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic signed [15:0] lowest_ff, lowest_in, highest_ff, highest_in;
   logic signed [15:0] current_ff, current_in;
   logic signed [15:0] run_lo_ff, run_lo_in, run_hi_ff, run_hi_in;
   logic ready_ff, ready_in, restart_ff, restart_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic signed [15:0] rd_x_ff, rd_y_ff;
   logic signed [15:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [15:0] x1_ff, x1_in;
   logic signed [16:0] dx_ff, dx_in;
   logic [31:0] num_ff, num_in;
   logic [15:0] den_ff, den_in, rem_ff, rem_in;
   logic [16:0] quo_ff, quo_in;
   logic [4:0] bit_ff, bit_in;
   logic signed [34:0] prod_ff, prod_in;
   logic signed [CROSS_W-1:0] val_ff, val_in, a_ff, a_in, b_ff, b_in;
   logic [CNT_W-1:0] ints_ff, ints_in, slot_ff, slot_in, pos_ff, pos_in;
   logic [SPAN_W-1:0] spans_ff, spans_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic cr_we;
   logic [IDX_W-1:0] cr_wa;
   logic signed [CROSS_W-1:0] cr_wd;

   logic out_free, req_accept, top;
   logic [CNT_W-1:0] eff_count;
   logic signed [15:0] lo_new, hi_new;
   logic signed [15:0] ey1, ey2, ex1, ex2;
   logic hit, oriented;
   logic [16:0] rem_sh;
   logic signed [CROSS_W-1:0] cr_prev, cr_a, cr_b, sa, sb;
   logic [CNT_W:0] pos_end;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign top = (current_ff == highest_ff);

   // Crossing reads for insertion and pairing.
   assign cr_prev = cross_ff[IDX_W'(slot_ff - CNT_W'(1))];
   assign cr_a = cross_ff[pos_ff[IDX_W-1:0]];
   assign cr_b = cross_ff[IDX_W'(pos_ff + CNT_W'(1))];
   assign pos_end = {1'b0, pos_ff} + (CNT_W+1)'(3);

   // Rounded span ends: floor(v / 65536) plus the half bit.
   assign sa = a_ff + CROSS_W'(1);
   assign sb = b_ff - CROSS_W'(1);

   // Edge orientation and row test.
   always_comb begin
      oriented = 1'b1;
      ey1 = prev_y_ff;
      ey2 = rd_y_ff;
      ex1 = prev_x_ff;
      ex2 = rd_x_ff;
      if (prev_y_ff > rd_y_ff) begin
         ey1 = rd_y_ff;
         ey2 = prev_y_ff;
         ex1 = rd_x_ff;
         ex2 = prev_x_ff;
      end else if (prev_y_ff == rd_y_ff) begin
         oriented = 1'b0;
      end
      hit = oriented && ((current_ff >= ey1 && current_ff < ey2) ||
                         (top && current_ff > ey1 && current_ff <= ey2));
   end

   assign rem_sh = {rem_ff, num_ff[31]};

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lowest_in = lowest_ff;
      highest_in = highest_ff;
      current_in = current_ff;
      run_lo_in = run_lo_ff;
      run_hi_in = run_hi_ff;
      ready_in = ready_ff;
      restart_in = restart_ff;
      idx_in = idx_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      x1_in = x1_ff;
      dx_in = dx_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      bit_in = bit_ff;
      prod_in = prod_ff;
      val_in = val_ff;
      a_in = a_ff;
      b_in = b_ff;
      ints_in = ints_ff;
      slot_in = slot_ff;
      pos_in = pos_ff;
      spans_in = spans_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0;
      mem_wa = '0;
      cr_we = 1'b0;
      cr_wa = slot_ff[IDX_W-1:0];
      cr_wd = val_ff;
      eff_count = restart_ff ? '0 : count_ff;
      lo_new = run_lo_ff;
      hi_new = run_hi_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               if (req_data.func == FUNC_VERTEX) begin
                  // Vertex store, with a running row range.
                  if (restart_ff) begin
                     restart_in = 1'b0;
                     ready_in = 1'b0;
                  end
                  rsp_data_in.kind = KIND_VERTEX;
                  if (eff_count < CNT_W'(MAX_CORNERS)) begin
                     mem_we = 1'b1;
                     mem_wa = eff_count[IDX_W-1:0];
                     count_in = eff_count + CNT_W'(1);
                     if (eff_count == '0) begin
                        lo_new = req_data.vert_y;
                        hi_new = req_data.vert_y;
                     end else begin
                        if (req_data.vert_y < run_lo_ff) lo_new = req_data.vert_y;
                        if (req_data.vert_y > run_hi_ff) hi_new = req_data.vert_y;
                     end
                     run_lo_in = lo_new;
                     run_hi_in = hi_new;
                  end else begin
                     count_in = CNT_W'(MAX_CORNERS + 1);
                     rsp_data_in.kind = KIND_ERROR;
                  end
                  if (req_data.last_vertex) begin
                     restart_in = 1'b1;
                     if (count_in < CNT_W'(3) || count_in > CNT_W'(MAX_CORNERS)) begin
                        rsp_data_in.kind = KIND_ERROR;
                     end else begin
                        lowest_in = lo_new;
                        highest_in = hi_new;
                        current_in = lo_new;
                        ready_in = 1'b1;
                     end
                  end
               end else if (!ready_ff) begin
                  rsp_data_in.kind = KIND_ERROR;
                  rsp_data_in.row_done = 1'b1;
               end else begin
                  rsp_valid_in = 1'b0;
                  idx_in = IDX_W'(count_ff - CNT_W'(1));
                  ints_in = '0;
                  state_in = ST_P1;
               end
            end
         end
         ST_P1: state_in = ST_P2;
         ST_P2: begin
            // Closing corner becomes the first edge's start.
            prev_x_in = rd_x_ff;
            prev_y_in = rd_y_ff;
            idx_in = '0;
            state_in = ST_RD;
         end
         ST_RD: state_in = ST_EDGE;
         ST_EDGE: begin
            if (hit) begin
               x1_in = ex1;
               dx_in = 17'(ex2) - 17'(ex1);
               num_in = {16'(17'(current_ff) - 17'(ey1)), 16'd0};
               den_in = 16'(17'(ey2) - 17'(ey1));
               rem_in = '0;
               quo_in = '0;
               bit_in = 5'd31;
               state_in = ST_DIV;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = 16'(rem_sh - {1'b0, den_ff});
               quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               rem_in = rem_sh[15:0];
               quo_in = {quo_ff[15:0], 1'b0};
            end
            num_in = {num_ff[30:0], 1'b0};
            bit_in = bit_ff - 5'd1;
            if (bit_ff == '0) state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = $signed({1'b0, quo_ff}) * dx_ff;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            val_in = CROSS_W'(prod_ff) + (CROSS_W'(x1_ff) <<< 16);
            slot_in = ints_ff;
            state_in = ST_INS;
         end
         ST_INS: begin
            // One insertion-sort step per cycle.
            cr_we = 1'b1;
            if (slot_ff != '0 && cr_prev > val_ff) begin
               cr_wd = cr_prev;
               slot_in = slot_ff - CNT_W'(1);
            end else begin
               cr_wd = val_ff;
               ints_in = ints_ff + CNT_W'(1);
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            prev_x_in = rd_x_ff;
            prev_y_in = rd_y_ff;
            if (CNT_W'(idx_ff) == count_ff - CNT_W'(1)) begin
               pos_in = '0;
               spans_in = '0;
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
               state_in = ST_RD;
            end
         end
         ST_EMIT: begin
            if (ints_ff >= CNT_W'(2)) begin
               state_in = ST_E1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               rsp_data_in.kind = KIND_EMPTY;
               rsp_data_in.span_row = current_ff;
               rsp_data_in.row_done = 1'b1;
               rsp_data_in.polygon_done = top;
               state_in = ST_IDLE;
               if (top) ready_in = 1'b0;
               else current_in = current_ff + 16'sd1;
            end
         end
         ST_E1: begin
            a_in = cr_a;
            state_in = ST_E2;
         end
         ST_E2: begin
            b_in = cr_b;
            state_in = ST_E3;
         end
         ST_E3: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.kind = KIND_SPAN;
               rsp_data_in.span_row = current_ff;
               rsp_data_in.span_start = sa[31:16] + {15'd0, sa[15]};
               rsp_data_in.span_end = sb[31:16] + {15'd0, sb[15]};
               rsp_data_in.polygon_done = top;
               rsp_data_in.row_done = 1'b0;
               if (pos_end >= {1'b0, ints_ff} || spans_ff == SPAN_W'(SPAN_CAP - 1)) begin
                  rsp_data_in.row_done = 1'b1;
                  state_in = ST_IDLE;
                  if (top) ready_in = 1'b0;
                  else current_in = current_ff + 16'sd1;
               end else begin
                  pos_in = pos_ff + CNT_W'(2);
                  spans_in = spans_ff + SPAN_W'(1);
                  state_in = ST_E1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Corner memory: one write port, registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         corner_x[mem_wa] <= req_data.vert_x;
         corner_y[mem_wa] <= req_data.vert_y;
      end
      rd_x_ff <= corner_x[idx_ff];
      rd_y_ff <= corner_y[idx_ff];
   end

   // Crossing registers.
   always_ff @(posedge clock) begin
      if (cr_we) cross_ff[cr_wa] <= cr_wd;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         lowest_ff <= '0;
         highest_ff <= '0;
         current_ff <= '0;
         ready_ff <= 1'b0;
         restart_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ints_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         lowest_ff <= lowest_in;
         highest_ff <= highest_in;
         current_ff <= current_in;
         ready_ff <= ready_in;
         restart_ff <= restart_in;
         rsp_valid_ff <= rsp_valid_in;
         ints_ff <= ints_in;
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      run_lo_ff <= run_lo_in;
      run_hi_ff <= run_hi_in;
      idx_ff <= idx_in;
      prev_x_ff <= prev_x_in;
      prev_y_ff <= prev_y_in;
      x1_ff <= x1_in;
      dx_ff <= dx_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
      prod_ff <= prod_in;
      val_ff <= val_in;
      a_ff <= a_in;
      b_ff <= b_in;
      slot_ff <= slot_in;
      pos_ff <= pos_in;
      spans_ff <= spans_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // A row walk only runs on a ready polygon.
   a_walk_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> ready_ff)
      else $error("row walk without a ready polygon");

   // Never more crossings than stored edges.
   a_ints_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> ints_ff <= count_ff)
      else $error("crossing count exceeds corner count");

   // A span result belongs to the row being walked.
   a_span_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_E3 && out_free |=> rsp_data_ff.span_row == $past(current_ff))
      else $error("span row mismatch");
`endif
endmodule
`default_nettype wire

>>> tb/sv/scanline_polygon_fill_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module scanline_polygon_fill_tb;
   import spf_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;

   scanline_polygon_fill dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Predictor state for the polygon being filled.
   logic signed [15:0] shadow_x [MAX_CORNERS];
   logic signed [15:0] shadow_y [MAX_CORNERS];
   int shadow_count;
   int shadow_low_row, shadow_high_row, shadow_row;
   bit shadow_ready, shadow_closed;

   req_type pending_requests[$];
   rsp_type expected_spans[$];
   int pause_marks[$];
   int sent_count;
   int mismatch_count = 0;
   bit idle_free;
   bit stimulus_done;

   // Append a request to the pending queue.
   function automatic void add_request(req_type r);
      pending_requests = {pending_requests, r};
   endfunction

   // Append a result to the expected queue.
   function automatic void add_result(rsp_type r);
      expected_spans = {expected_spans, r};
   endfunction

   // Round a 16.16 value to nearest, ties upward.
   function automatic logic signed [15:0] round_fixed(longint v);
      longint fl;
      fl = v >>> 16;
      return 16'(fl + ((v >> 15) & 1));
   endfunction

   function automatic rsp_type make_rsp(logic [1:0] k, int row, int xs, int xe,
                                        bit rd, bit pd);
      rsp_type r;
      r.kind = k;
      r.span_row = 16'(row);
      r.span_start = 16'(xs);
      r.span_end = 16'(xe);
      r.row_done = rd;
      r.polygon_done = pd;
      return r;
   endfunction

   // Compute the expected results of one accepted request.
   task automatic predict_request(req_type rq);
      longint hits [$];
      longint q, v;
      int ya, yb, x1, x2, y1, y2, p, y, spans, j;
      bit top;
      logic [1:0] k;
      rsp_type r;
      if (rq.func == FUNC_VERTEX) begin
         k = KIND_VERTEX;
         if (shadow_closed) begin
            shadow_closed = 0;
            shadow_count = 0;
            shadow_ready = 0;
         end
         if (shadow_count < MAX_CORNERS) begin
            shadow_x[shadow_count] = rq.vert_x;
            shadow_y[shadow_count] = rq.vert_y;
            shadow_count++;
         end else begin
            shadow_count = MAX_CORNERS + 1;
            k = KIND_ERROR;
         end
         if (rq.last_vertex) begin
            shadow_closed = 1;
            if (shadow_count < 3 || shadow_count > MAX_CORNERS) begin
               k = KIND_ERROR;
            end else begin
               shadow_low_row = shadow_y[0];
               shadow_high_row = shadow_y[0];
               for (int i = 1; i < shadow_count; i++) begin
                  if (shadow_y[i] < shadow_low_row) shadow_low_row = shadow_y[i];
                  if (shadow_y[i] > shadow_high_row) shadow_high_row = shadow_y[i];
               end
               shadow_row = shadow_low_row;
               shadow_ready = 1;
            end
         end
         add_result(make_rsp(k, 0, 0, 0, 1'b0, 1'b0));
         return;
      end
      if (!shadow_ready) begin
         add_result(make_rsp(KIND_ERROR, 0, 0, 0, 1'b1, 1'b0));
         return;
      end
      y = shadow_row;
      top = (y == shadow_high_row);
      // Gather the crossing of every non-horizontal edge that meets the row.
      for (int i = 0; i < shadow_count; i++) begin
         p = (i == 0) ? shadow_count - 1 : i - 1;
         ya = shadow_y[p];
         yb = shadow_y[i];
         if (ya == yb) continue;
         if (ya < yb) begin
            y1 = ya; y2 = yb; x1 = shadow_x[p]; x2 = shadow_x[i];
         end else begin
            y1 = yb; y2 = ya; x1 = shadow_x[i]; x2 = shadow_x[p];
         end
         if ((y >= y1 && y < y2) || (top && y > y1 && y <= y2)) begin
            q = (longint'(65536) * longint'(y - y1)) / longint'(y2 - y1);
            hits = {hits, q * longint'(x2 - x1) + longint'(65536) * x1};
         end
      end
      // Insertion sort, ascending.
      for (int i = 1; i < hits.size(); i++) begin
         v = hits[i];
         j = i;
         while (j > 0 && hits[j - 1] > v) begin
            hits[j] = hits[j - 1];
            j--;
         end
         hits[j] = v;
      end
      spans = 0;
      for (int i = 0; i + 1 < hits.size() && spans < SPAN_CAP; i += 2) begin
         r = make_rsp(KIND_SPAN, y, round_fixed(hits[i] + 1),
                      round_fixed(hits[i + 1] - 1), 1'b0, top);
         spans++;
         if (!(i + 3 < hits.size() && spans < SPAN_CAP)) r.row_done = 1;
         add_result(r);
      end
      if (spans == 0) add_result(make_rsp(KIND_EMPTY, y, 0, 0, 1'b1, top));
      if (top) shadow_ready = 0;
      else shadow_row = y + 1;
   endtask

   function automatic req_type vertex_req(int x, int y, bit last);
      req_type r;
      r.func = FUNC_VERTEX;
      r.vert_x = 16'(x);
      r.vert_y = 16'(y);
      r.last_vertex = last;
      return r;
   endfunction

   function automatic req_type row_req();
      req_type r;
      r.func = FUNC_ROW;
      r.vert_x = 16'($urandom);
      r.vert_y = 16'($urandom);
      r.last_vertex = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Queue a random polygon of n corners, compact in y, then rows over it.
   task automatic queue_polygon(int n, int rows, bit wide);
      int bx, by, h;
      bx = wide ? $urandom_range(0, 65535) - 32768 : $urandom_range(0, 400) - 200;
      by = $urandom_range(0, 200) - 100;
      h = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         if (wide)
            add_request(vertex_req($urandom_range(0, 65535) - 32768,
               by + $urandom_range(0, h), i == n - 1));
         else
            add_request(vertex_req(bx + $urandom_range(0, 60) - 30,
               by + $urandom_range(0, h), i == n - 1));
      end
      for (int i = 0; i < rows; i++) add_request(row_req());
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Stimulus: directed cases first, then random polygons.
   initial begin
      stimulus_done = 0;
      add_request(row_req());
      add_request(vertex_req(32767, -32768, 0));
      add_request(vertex_req(-32768, 32767, 0));
      add_request(vertex_req(0, 0, 1));
      add_request(row_req());
      add_request(vertex_req(5, 5, 0));
      add_request(vertex_req(9, 5, 1));
      add_request(row_req());
      add_request(vertex_req(0, 0, 0));
      add_request(vertex_req(10, 0, 0));
      add_request(vertex_req(10, 2, 0));
      add_request(vertex_req(0, 2, 1));
      for (int i = 0; i < 4; i++) add_request(row_req());
      for (int i = 0; i < 17; i++)
         add_request(vertex_req(i * 3, (i % 2) ? 4 : 0, i == 16));
      pause_marks = {pause_marks, pending_requests.size()};
      // Sixteen-corner zigzag: many crossings, capped spans.
      for (int i = 0; i < 16; i++)
         add_request(vertex_req(i * 10, (i % 2) ? 4 : 0, i == 15));
      for (int i = 0; i < 6; i++) add_request(row_req());
      while (pending_requests.size() < 410) begin
         case ($urandom_range(0, 9))
            0: queue_polygon($urandom_range(1, 2), $urandom_range(0, 2), 0);
            1: queue_polygon($urandom_range(3, 16), $urandom_range(1, 4), 1);
            2: queue_polygon(18, 1, 0);
            default: queue_polygon($urandom_range(3, 16), $urandom_range(1, 9), 0);
         endcase
      end
      pause_marks = {pause_marks, pending_requests.size() / 2};
      stimulus_done = 1;
   end

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_data <= '0;
         sent_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_request(req_data);
            sent_count <= sent_count + 1;
         end
         if (req_valid && req_stall) begin
            // Hold the stalled request.
         end else if (pending_requests.size() != 0 &&
                      (idle_free || $urandom_range(0, 99) >= 21) &&
                      !(pause_marks.size() != 0 &&
                        pause_marks[0] == sent_count + (req_valid ? 1 : 0) &&
                        (req_valid || expected_spans.size() != 0))) begin
            if (pause_marks.size() != 0 &&
                pause_marks[0] == sent_count + (req_valid ? 1 : 0))
               void'(pause_marks.pop_front());
            req_valid <= 1;
            req_data <= pending_requests.pop_front();
         end else begin
            req_valid <= 0;
         end
      end
   end

   // Monitor and receiver stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_spans.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result %p", rsp_data);
            end else if (rsp_data !== expected_spans[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p, got %p", expected_spans[0], rsp_data);
               void'(expected_spans.pop_front());
            end else begin
               void'(expected_spans.pop_front());
            end
         end
         rsp_stall <= !idle_free && ($urandom_range(0, 99) < 21);
      end
   end

   // Idle-free stretch in the middle of the run.
   always @(posedge clock) idle_free <= (sent_count > 150 && sent_count < 260);

   initial begin
      reset = 1;
      repeat (10) @(posedge clock);
      reset <= 0;
      wait (stimulus_done && pending_requests.size() == 0 && !req_valid);
      wait (expected_spans.size() == 0);
      repeat (1000) @(posedge clock);
      if (mismatch_count == 0 && expected_spans.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
